>>> sv/pft_pkg.sv
// Package: shared widths, defaults, action codes and state type for the page frame table.
`default_nettype none
package pft_pkg;

    localparam int PFT_NUM_FRAMES = 128;

    localparam int ACTION_W = 2;
    localparam int OWNER_W  = 8;
    localparam int PAGE_W   = 10;
    localparam int NEED_W   = 8;
    localparam int IDX_W    = 7;
    localparam int FREE_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CHECK = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLAIM = 2'd2,
        ACT_FREE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage
`default_nettype wire

>>> sv/pft_if.sv
// Interfaces: request and response channels of the page frame table.
`default_nettype none
interface pft_in_if;
    import pft_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [OWNER_W-1:0]  owner_id;
    logic [PAGE_W-1:0]   page_number;
    logic [NEED_W-1:0]   needed_count;

    modport source (output valid, action, owner_id, page_number, needed_count, input ready);
    modport sink   (input valid, action, owner_id, page_number, needed_count, output ready);
endinterface

interface pft_out_if;
    import pft_pkg::*;
    logic              valid;
    logic              ready;
    logic              success;
    logic [IDX_W-1:0]  frame_index;
    logic [FREE_W-1:0] free_frames;

    modport source (output valid, success, frame_index, free_frames, input ready);
    modport sink   (input valid, success, frame_index, free_frames, output ready);
endinterface
`default_nettype wire

>>> sv/page_frame_table.sv
// Top level: page frame table, frame entries held in one synchronous memory and scanned in turn.
// Flow: a free count check goes from the request beat to the finish state; lookup, claim and
//   free owner first walk every frame. The finish state loads the registered result beat.
// Throughput: one request at a time; the walking actions read each frame in turn through the
//   single read port of the frame memory (one entry per cycle).
// Reset: synchronous, active low. After reset a clearing pass over all NUM_FRAMES entries marks
//   every frame free; no request beat is taken until it ends.
`default_nettype none
module page_frame_table #(
    parameter int NUM_FRAMES = pft_pkg::PFT_NUM_FRAMES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pft_in_if.sink      i_in,
    pft_out_if.source   o_out
);
    import pft_pkg::*;

    // Address and free count widths follow the table size; the compare width is the wider of those and NEED_W.
    localparam int AW    = $clog2(NUM_FRAMES);
    localparam int CW    = $clog2(NUM_FRAMES + 1);
    localparam int CMPW  = (CW > NEED_W) ? CW : NEED_W;
    localparam int ENT_W = 1 + OWNER_W + PAGE_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_FRAMES - 1);
    localparam logic [CW-1:0] FULL_FREE = CW'(NUM_FRAMES);

    // Entry layout: {used, owner, page}.
    logic [ENT_W-1:0] mem [NUM_FRAMES];

    t_state             r_state, n_state;
    logic [AW-1:0]      r_addr, n_addr;        // next address to read (or clear)
    logic               r_issue, n_issue;      // reads still to be issued in this walk
    logic               r_rd_valid;            // read data below belongs to this walk
    logic [AW-1:0]      r_rd_addr;
    logic [ENT_W-1:0]   r_rd_data;
    t_action            r_act, n_act;
    logic [OWNER_W-1:0] r_owner, n_owner;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic               r_found, n_found;
    logic [AW-1:0]      r_idx, n_idx;
    logic               r_ok, n_ok;
    logic [CW-1:0]      r_free, n_free;        // running count of free frames

    logic               r_out_valid, n_out_valid;
    logic               r_out_success;
    logic [IDX_W-1:0]   r_out_idx;
    logic [FREE_W-1:0]  r_out_free;

    // Combinational control.
    logic               w_accept;
    logic               w_load_out;
    logic               w_re;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [ENT_W-1:0]   w_wdata;
    logic               w_last;
    logic               w_used;
    logic [OWNER_W-1:0] w_ent_owner;
    logic [PAGE_W-1:0]  w_ent_page;
    logic [CMPW-1:0]    w_free_ext;
    logic [CMPW-1:0]    w_need_ext;
    logic [AW+IDX_W-1:0]  w_idx_wide;
    logic [CW+FREE_W-1:0] w_free_wide;

    assign w_used      = r_rd_data[ENT_W-1];
    assign w_ent_owner = r_rd_data[PAGE_W +: OWNER_W];
    assign w_ent_page  = r_rd_data[PAGE_W-1:0];
    assign w_last      = r_rd_valid && (r_rd_addr == LAST_ADDR);
    assign w_free_ext  = CMPW'(r_free);
    assign w_need_ext  = CMPW'(i_in.needed_count);
    assign w_idx_wide  = {{IDX_W{1'b0}}, r_idx};
    assign w_free_wide = {{FREE_W{1'b0}}, r_free};

    // Handshake and memory strobes.
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        w_accept   = i_in.valid && (r_state == S_IDLE);
        w_load_out = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);
        w_re       = (r_state == S_SCAN) && r_issue;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (t_action'(i_in.action) == ACT_CHECK) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Walk datapath: read one entry per cycle, act on the previous one, write back claims and frees.
    always_comb begin
        n_addr      = r_addr;
        n_issue     = r_issue;
        n_act       = r_act;
        n_owner     = r_owner;
        n_page      = r_page;
        n_found     = r_found;
        n_idx       = r_idx;
        n_ok        = r_ok;
        n_free      = r_free;
        w_we        = 1'b0;
        w_waddr     = r_rd_addr;
        w_wdata     = '0;
        n_out_valid = r_out_valid && !o_out.ready;

        case (r_state)
            S_CLEAR: begin
                // Sweep the memory, marking each frame free.
                w_we    = 1'b1;
                w_waddr = r_addr;
                n_addr  = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) n_addr = '0;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_act   = t_action'(i_in.action);
                    n_owner = i_in.owner_id;
                    n_page  = i_in.page_number;
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_addr  = '0;
                    n_issue = 1'b1;
                    n_ok    = (w_free_ext >= w_need_ext);
                end
            end
            S_SCAN: begin
                if (r_issue) begin
                    if (r_addr == LAST_ADDR) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_rd_valid) begin
                    case (r_act)
                        ACT_LOOKUP: begin
                            if (!r_found && w_used && w_ent_owner == r_owner &&
                                w_ent_page == r_page) begin
                                n_found = 1'b1;
                                n_idx   = r_rd_addr;
                            end
                        end
                        ACT_CLAIM: begin
                            // Take the lowest free frame; later ones are left alone.
                            if (!r_found && !w_used) begin
                                n_found = 1'b1;
                                n_idx   = r_rd_addr;
                                w_we    = 1'b1;
                                w_wdata = {1'b1, r_owner, r_page};
                                n_free  = r_free - CW'(1);
                            end
                        end
                        ACT_FREE: begin
                            if (w_used && w_ent_owner == r_owner) begin
                                w_we    = 1'b1;
                                w_wdata = '0;
                                n_free  = r_free + CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                if (w_last) begin
                    n_ok = (r_act == ACT_FREE) ? 1'b1 : n_found;
                end
            end
            S_FINISH: begin
                if (w_load_out) n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    // Frame memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_free      <= FULL_FREE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_rd_valid  <= w_re;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_addr;
        r_act     <= n_act;
        r_owner   <= n_owner;
        r_page    <= n_page;
        r_found   <= n_found;
        r_idx     <= n_idx;
        r_ok      <= n_ok;
        if (w_load_out) begin
            r_out_success <= r_ok;
            r_out_idx     <= r_found ? w_idx_wide[IDX_W-1:0] : '0;
            r_out_free    <= w_free_wide[FREE_W-1:0];
        end
    end

    // Hold the result beat until the sink takes it.
    assign o_out.valid       = r_out_valid;
    assign o_out.success     = r_out_success;
    assign o_out.frame_index = r_out_idx;
    assign o_out.free_frames = r_out_free;

endmodule
`default_nettype wire

>>> bench/tb_page_frame_table.sv
`timescale 1ns / 1ps
// Testbench: drives frame table requests, predicts every response beat and compares it.
module tb_page_frame_table;
    import pft_pkg::*;

    localparam int FRAMES  = PFT_NUM_FRAMES;
    localparam int MAX_GAP = 18;
    localparam int POOL_SZ = 6;

    typedef struct packed {
        logic              success;
        logic [IDX_W-1:0]  frame_index;
        logic [FREE_W-1:0] free_frames;
    } t_frame_result;

    logic clk;
    logic rst_n;

    pft_in_if  req_if ();
    pft_out_if rsp_if ();

    page_frame_table i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    // Shadow copy of the frame store, updated at each accepted request beat.
    bit                 frame_busy   [FRAMES];
    logic [OWNER_W-1:0] frame_holder [FRAMES];
    logic [PAGE_W-1:0]  frame_vpage  [FRAMES];

    // Responses still owed by the block, oldest first.
    t_frame_result      pending_results [$];
    int unsigned        mismatch_count;

    // Set during stretches where neither side inserts idle cycles.
    bit                 no_idle;

    // A handful of owners reused often, so lookups hit and frees release many frames.
    logic [OWNER_W-1:0] owner_pool [POOL_SZ];

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned count_free_frames();
        int unsigned n;
        n = 0;
        for (int i = 0; i < FRAMES; i++) begin
            if (!frame_busy[i]) n++;
        end
        return n;
    endfunction

    // Apply one action to the shadow store and return the response it must produce.
    function automatic t_frame_result apply_frame_action(t_action act,
                                                         logic [OWNER_W-1:0] owner,
                                                         logic [PAGE_W-1:0] vpage,
                                                         logic [NEED_W-1:0] need);
        t_frame_result r;
        bit            found;
        r     = '0;
        found = 1'b0;
        case (act)
            ACT_CHECK: begin
                r.success = (count_free_frames() >= need);
            end
            ACT_LOOKUP: begin
                // Lowest matching frame wins when a pair is held more than once.
                for (int i = 0; i < FRAMES && !found; i++) begin
                    if (frame_busy[i] && frame_holder[i] == owner && frame_vpage[i] == vpage) begin
                        found         = 1'b1;
                        r.success     = 1'b1;
                        r.frame_index = IDX_W'(i);
                    end
                end
            end
            ACT_CLAIM: begin
                // Take the lowest free frame; no duplicate check on the pair.
                for (int i = 0; i < FRAMES && !found; i++) begin
                    if (!frame_busy[i]) begin
                        found           = 1'b1;
                        frame_busy[i]   = 1'b1;
                        frame_holder[i] = owner;
                        frame_vpage[i]  = vpage;
                        r.success       = 1'b1;
                        r.frame_index   = IDX_W'(i);
                    end
                end
            end
            default: begin
                // Release every frame of the owner; always reports success.
                for (int i = 0; i < FRAMES; i++) begin
                    if (frame_busy[i] && frame_holder[i] == owner) begin
                        frame_busy[i]   = 1'b0;
                        frame_holder[i] = '0;
                        frame_vpage[i]  = '0;
                    end
                end
                r.success = 1'b1;
            end
        endcase
        r.free_frames = FREE_W'(count_free_frames());
        return r;
    endfunction

    // Present one request beat after a random gap and hold it until it is taken.
    task automatic send_request(t_action act, logic [OWNER_W-1:0] owner,
                                logic [PAGE_W-1:0] vpage, logic [NEED_W-1:0] need);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.action       = act;
        req_if.owner_id     = owner;
        req_if.page_number  = vpage;
        req_if.needed_count = need;
        req_if.valid        = 1'b1;
        do @(posedge clk); while (!req_if.ready);
        pending_results.push_back(apply_frame_action(act, owner, vpage, need));
    endtask

    // Response side: stall a random number of cycles before taking each beat.
    initial begin
        int unsigned gap;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            @(negedge clk);
            if (gap != 0) begin
                rsp_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
            do @(posedge clk); while (!rsp_if.valid);
        end
    end

    // Compare each response beat with the oldest outstanding prediction.
    always @(posedge clk) begin : check_responses
        t_frame_result want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: expected no response, actual success=%0b index=%0d free=%0d",
                         $realtime, rsp_if.success, rsp_if.frame_index, rsp_if.free_frames);
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.success !== want.success) begin
                    mismatch_count++;
                    $display("%0t: success expected %0b actual %0b", $realtime,
                             want.success, rsp_if.success);
                end
                if (rsp_if.frame_index !== want.frame_index) begin
                    mismatch_count++;
                    $display("%0t: frame_index expected %0d actual %0d", $realtime,
                             want.frame_index, rsp_if.frame_index);
                end
                if (rsp_if.free_frames !== want.free_frames) begin
                    mismatch_count++;
                    $display("%0t: free_frames expected %0d actual %0d", $realtime,
                             want.free_frames, rsp_if.free_frames);
                end
            end
        end
    end

    function automatic logic [OWNER_W-1:0] pick_owner();
        if ($urandom_range(0, 99) < 80) return owner_pool[$urandom_range(0, POOL_SZ - 1)];
        return OWNER_W'($urandom_range(0, 255));
    endfunction

    // Return the index of some held frame, or -1 when the table is empty.
    function automatic int pick_held_frame();
        int start;
        start = $urandom_range(0, FRAMES - 1);
        for (int k = 0; k < FRAMES; k++) begin
            if (frame_busy[(start + k) % FRAMES]) return (start + k) % FRAMES;
        end
        return -1;
    endfunction

    // Needed counts: half anywhere in the field, half close to the current free count.
    function automatic logic [NEED_W-1:0] pick_need();
        int n;
        if ($urandom_range(0, 1) == 0) return NEED_W'($urandom_range(0, 255));
        n = int'(count_free_frames()) + int'($urandom_range(0, 4)) - 2;
        if (n < 0) n = 0;
        if (n > 255) n = 255;
        return NEED_W'(n);
    endfunction

    // Free counts at the extremes straight after reset, with an empty table.
    task automatic test_free_count_extremes();
        send_request(ACT_CHECK, 8'd0, 10'd0, 8'd0);
        send_request(ACT_CHECK, 8'hFF, 10'h3FF, 8'd1);
        send_request(ACT_CHECK, 8'd0, 10'd0, 8'd128);
        send_request(ACT_CHECK, 8'd0, 10'd0, 8'd129);
        send_request(ACT_CHECK, 8'd0, 10'd0, 8'd255);
    endtask

    // Claims at the field extremes, a duplicate pair, hits and misses, and checks around the free count.
    task automatic test_claim_and_lookup();
        send_request(ACT_CLAIM, 8'd0, 10'd0, 8'd0);
        send_request(ACT_CLAIM, 8'hFF, 10'h3FF, 8'hFF);
        send_request(ACT_CLAIM, 8'hFF, 10'h3FF, 8'd0);
        send_request(ACT_LOOKUP, 8'hFF, 10'h3FF, 8'd0);
        send_request(ACT_LOOKUP, 8'hFF, 10'd0, 8'd0);
        send_request(ACT_LOOKUP, 8'd0, 10'd0, 8'd0);
        send_request(ACT_LOOKUP, 8'd0, 10'h3FF, 8'd0);
        send_request(ACT_CHECK, 8'd0, 10'd0, 8'd125);
        send_request(ACT_CHECK, 8'd0, 10'd0, 8'd126);
    endtask

    // Freeing an owner with nothing held, then one with two frames, reuse of the gap, then the rest.
    task automatic test_free_owner();
        send_request(ACT_FREE, 8'd7, 10'd0, 8'd0);
        send_request(ACT_FREE, 8'hFF, 10'd0, 8'd0);
        send_request(ACT_LOOKUP, 8'hFF, 10'h3FF, 8'd0);
        send_request(ACT_CLAIM, 8'hAA, 10'h155, 8'd0);
        send_request(ACT_FREE, 8'd0, 10'd0, 8'd0);
        send_request(ACT_FREE, 8'hAA, 10'd0, 8'd0);
    endtask

    // Fill the table, claim once more with nothing free, check and look up, then drain it owner by owner.
    task automatic test_table_full();
        int f;
        int held;
        while (count_free_frames() != 0) begin
            send_request(ACT_CLAIM, OWNER_W'($urandom_range(0, 255)),
                         PAGE_W'($urandom_range(0, 1023)), NEED_W'($urandom_range(0, 255)));
        end
        send_request(ACT_CLAIM, pick_owner(), PAGE_W'($urandom_range(0, 1023)), 8'd0);
        send_request(ACT_CHECK, 8'd0, 10'd0, 8'd1);
        send_request(ACT_CHECK, 8'd0, 10'd0, 8'd0);
        held = pick_held_frame();
        send_request(ACT_LOOKUP, frame_holder[held], frame_vpage[held], 8'd0);
        while (count_free_frames() < FRAMES) begin
            f = pick_held_frame();
            send_request(ACT_FREE, frame_holder[f], PAGE_W'($urandom_range(0, 1023)),
                         NEED_W'($urandom_range(0, 255)));
        end
    endtask

    // Random mix; claim_pct sets how hard the table is pushed towards full.
    task automatic run_random_mix(int unsigned count, int unsigned claim_pct);
        int unsigned roll;
        int          held;
        for (int unsigned n = 0; n < count; n++) begin
            // Switch idling on or off in stretches so gaps land on every phase.
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < claim_pct) begin
                send_request(ACT_CLAIM, pick_owner(), PAGE_W'($urandom_range(0, 1023)),
                             NEED_W'($urandom_range(0, 255)));
            end else if (roll < claim_pct + 30) begin
                held = pick_held_frame();
                if (held >= 0 && $urandom_range(0, 99) < 70) begin
                    send_request(ACT_LOOKUP, frame_holder[held], frame_vpage[held],
                                 NEED_W'($urandom_range(0, 255)));
                end else begin
                    send_request(ACT_LOOKUP, pick_owner(), PAGE_W'($urandom_range(0, 1023)),
                                 NEED_W'($urandom_range(0, 255)));
                end
            end else if (roll < claim_pct + 45) begin
                send_request(ACT_CHECK, pick_owner(), PAGE_W'($urandom_range(0, 1023)),
                             pick_need());
            end else begin
                send_request(ACT_FREE, pick_owner(), PAGE_W'($urandom_range(0, 1023)),
                             NEED_W'($urandom_range(0, 255)));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        req_if.valid        = 1'b0;
        req_if.action       = ACT_CHECK;
        req_if.owner_id     = '0;
        req_if.page_number  = '0;
        req_if.needed_count = '0;
        rst_n               = 1'b0;
        no_idle             = 1'b0;
        mismatch_count      = 0;
        for (int i = 0; i < FRAMES; i++) begin
            frame_busy[i]   = 1'b0;
            frame_holder[i] = '0;
            frame_vpage[i]  = '0;
        end
        for (int i = 0; i < POOL_SZ; i++) owner_pool[i] = OWNER_W'($urandom_range(0, 255));

        // Hold reset, then release it at a falling edge; the clearing pass after it is covered by
        // the handshake.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_free_count_extremes();
        test_claim_and_lookup();
        test_free_owner();
        test_table_full();
        run_random_mix(800, 45);
        run_random_mix(650, 30);

        @(negedge clk);
        req_if.valid = 1'b0;

        // Drain outstanding responses, then allow one full walk for any stray beat.
        wait (pending_results.size() == 0);
        repeat (FRAMES + 8) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
